FILE: design/nps_pkg.sv
`default_nettype none

package nps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ARR_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 21;
  localparam int SUM_W = 25;
  localparam int INDEX_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic done;
  } scan_ctl_t;

  typedef struct packed {
    logic               found;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   earliest;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_CALC1,
    ST_CALC2,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/nps_ram.sv
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/nps_scan.sv
`default_nettype none

module nps_scan #(
  parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF,
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  wire logic                      clk,
  input  wire nps_pkg::scan_ctl_t        ctl,
  input  wire logic [IW-1:0]             idx,
  input  wire nps_pkg::job_t             job,
  input  wire logic [nps_pkg::TIME_W-1:0] cur_time,
  output nps_pkg::scan_res_t             res,
  output logic      [IW-1:0]             pick
);

  import nps_pkg::*;

  logic              any;
  logic [PRIO_W-1:0] best;
  logic              eligible;
  logic              take;
  logic              earlier;

  // The first job with the smallest priority value wins, so only a strictly
  // smaller value replaces the current choice.
  always_comb begin
    eligible = !ctl.done && ({{(TIME_W - ARR_W){1'b0}}, job.arrival} <= cur_time);
    take = ctl.valid && eligible && (!res.found || (job.prio < best));
    earlier = ctl.valid && !ctl.done && (!any || (job.arrival < res.earliest));
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      res.found <= 1'b0;
      any <= 1'b0;
    end else begin
      if (take) begin
        res.found <= 1'b1;
        best <= job.prio;
        pick <= idx;
        res.arrival <= job.arrival;
        res.burst <= job.burst;
      end
      if (earlier) begin
        any <= 1'b1;
        res.earliest <= job.arrival;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/nonpreemptive_priority_scheduler.sv
`default_nettype none

// Non-preemptive priority scheduler. Jobs are taken one per cycle while
// in ST_LOAD and kept in a job RAM of MAX_PROCS entries; jobs beyond that
// are dropped. The job flagged last_process starts a run that holds
// job_stall high until every stored job has been reported. Each pick is a
// scan over the n stored jobs through the RAM's single read port, then a
// decision in ST_DECIDE; when nothing has arrived yet the clock jumps to
// the earliest pending arrival and the scan repeats once. A picked job then
// passes through the arithmetic states ST_CALC1 and ST_CALC2 before its
// result is registered from ST_EMIT once the result channel is free. Results
// are requests on the result channel, one per job in completion order, with
// last_result set on the final one; the next batch may be loaded while that result waits.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        job_valid,
  output logic                             job_stall,
  input  wire logic [nps_pkg::ARR_W-1:0]   arrival_time,
  input  wire logic [nps_pkg::BURST_W-1:0] burst_time,
  input  wire logic [nps_pkg::PRIO_W-1:0]  priority_level,
  input  wire logic                        last_process,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [nps_pkg::INDEX_W-1:0]      proc_index,
  output logic [nps_pkg::TIME_W-1:0]       start_time,
  output logic [nps_pkg::TIME_W-1:0]       completion_time,
  output logic [nps_pkg::TIME_W-1:0]       wait_time,
  output logic [nps_pkg::TIME_W-1:0]       turnaround_time,
  output logic [nps_pkg::SUM_W-1:0]        total_wait,
  output logic [nps_pkg::SUM_W-1:0]        total_turnaround,
  output logic                             last_result
);

  import nps_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_PROCS);

  state_t state;
  state_t state_next;

  logic [CW-1:0]        count;
  logic [CW-1:0]        finished;
  logic [CW-1:0]        scan_cnt;
  logic [MAX_PROCS-1:0] done;
  logic [TIME_W-1:0]    cur_time;
  logic [SUM_W-1:0]     wait_sum;
  logic [SUM_W-1:0]     tat_sum;
  logic                 rd_valid;
  logic [IW-1:0]        rd_idx;
  logic [TIME_W-1:0]    wait_r;
  logic [TIME_W-1:0]    comp_r;
  logic [TIME_W-1:0]    tat_r;

  job_t      wr_job;
  job_t      rd_job;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;
  logic [IW-1:0] pick;

  logic job_accept;
  logic store;
  logic emit;
  logic run_end;
  logic out_free;

  logic [TIME_W:0]  comp_sum;
  logic [TIME_W:0]  tat_full;
  logic [SUM_W:0]   wsum_full;
  logic [SUM_W:0]   tsum_full;

  assign wr_job = '{arrival: arrival_time, burst: burst_time, prio: priority_level};

  nps_ram #(
    .WIDTH($bits(job_t)),
    .DEPTH(MAX_PROCS)
  ) u_job_ram (
    .clk  (clk),
    .we   (store),
    .waddr(count[IW-1:0]),
    .wdata(wr_job),
    .raddr(scan_cnt[IW-1:0]),
    .rdata(rd_job)
  );

  assign scan_ctl = '{
    clear: (state == ST_SCAN) && (scan_cnt == '0),
    valid: rd_valid,
    done:  done[rd_idx]
  };

  nps_scan #(
    .MAX_PROCS(MAX_PROCS)
  ) u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .idx     (rd_idx),
    .job     (rd_job),
    .cur_time(cur_time),
    .res     (scan_res),
    .pick    (pick)
  );

  always_comb begin
    comp_sum = {1'b0, cur_time} + (TIME_W + 1)'(scan_res.burst);
    tat_full = {1'b0, wait_r} + (TIME_W + 1)'(scan_res.burst);
    wsum_full = {1'b0, wait_sum} + (SUM_W + 1)'(wait_r);
    tsum_full = {1'b0, tat_sum} + (SUM_W + 1)'(tat_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_stall = 1'b1;
    job_accept = 1'b0;
    store = 1'b0;
    emit = 1'b0;
    run_end = 1'b0;
    out_free = !result_valid || !result_stall;
    case (state)
      ST_LOAD: begin
        job_stall = 1'b0;
        job_accept = job_valid;
        store = job_valid && (count < CAP);
        if (job_valid && last_process) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((scan_cnt == count) && !rd_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = scan_res.found ? ST_CALC1 : ST_SCAN;
      end
      ST_CALC1: begin
        state_next = ST_CALC2;
      end
      ST_CALC2: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          run_end = (finished + 1'b1) == count;
          state_next = run_end ? ST_LOAD : ST_SCAN;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      finished <= '0;
      scan_cnt <= '0;
      done <= '0;
      cur_time <= '0;
      wait_sum <= '0;
      tat_sum <= '0;
      rd_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN) && (scan_cnt < count);
      rd_idx <= scan_cnt[IW-1:0];
      if (store) begin
        count <= count + 1'b1;
      end
      if (job_accept && last_process) begin
        scan_cnt <= '0;
        finished <= '0;
        cur_time <= '0;
      end
      if ((state == ST_SCAN) && (scan_cnt < count)) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if ((state == ST_DECIDE) && !scan_res.found) begin
        cur_time <= TIME_W'(scan_res.earliest);
        scan_cnt <= '0;
      end
      if (state == ST_CALC1) begin
        wait_r <= cur_time - TIME_W'(scan_res.arrival);
        comp_r <= comp_sum[TIME_W] ? TIME_MAX : comp_sum[TIME_W-1:0];
      end
      if (state == ST_CALC2) begin
        tat_r <= tat_full[TIME_W] ? TIME_MAX : tat_full[TIME_W-1:0];
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (emit) begin
        result_valid <= 1'b1;
        proc_index <= INDEX_W'(pick);
        start_time <= cur_time;
        completion_time <= comp_r;
        wait_time <= wait_r;
        turnaround_time <= tat_r;
        total_wait <= wsum_full[SUM_W] ? SUM_MAX : wsum_full[SUM_W-1:0];
        total_turnaround <= tsum_full[SUM_W] ? SUM_MAX : tsum_full[SUM_W-1:0];
        last_result <= run_end;
        scan_cnt <= '0;
        if (run_end) begin
          count <= '0;
          finished <= '0;
          done <= '0;
          cur_time <= '0;
          wait_sum <= '0;
          tat_sum <= '0;
        end else begin
          finished <= finished + 1'b1;
          done[pick] <= 1'b1;
          cur_time <= comp_r;
          wait_sum <= wsum_full[SUM_W] ? SUM_MAX : wsum_full[SUM_W-1:0];
          tat_sum <= tsum_full[SUM_W] ? SUM_MAX : tsum_full[SUM_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/nonpreemptive_priority_scheduler_tb.sv
module nonpreemptive_priority_scheduler_tb;
  import nps_pkg::*;

  localparam int JOB_SLOTS = MAX_PROCS_DEF;
  localparam int ITEM_TARGET = 480;
  localparam int QUIET_FROM = 420;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  finish;
    logic [TIME_W-1:0]  waited;
    logic [TIME_W-1:0]  turnaround;
    logic [SUM_W-1:0]   wait_total;
    logic [SUM_W-1:0]   tat_total;
    logic               final_job;
  } job_result_t;

  class sched_scoreboard;
    logic [ARR_W-1:0]   arr_q[JOB_SLOTS];
    logic [BURST_W-1:0] burst_q[JOB_SLOTS];
    logic [PRIO_W-1:0]  prio_q[JOB_SLOTS];
    bit                 done_q[JOB_SLOTS];
    int unsigned        loaded;
    job_result_t        expected_results[$];
    int                 errors;
    int                 results_seen;

    function new();
      loaded = 0;
      errors = 0;
      results_seen = 0;
      foreach (done_q[i]) done_q[i] = 1'b0;
    endfunction

    function longint unsigned sat(longint unsigned v, longint unsigned lim);
      return (v > lim) ? lim : v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_job(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst,
                           logic [PRIO_W-1:0] prio, logic last);
      int unsigned finished;
      int unsigned pick;
      logic [PRIO_W-1:0] best;
      bit found;
      bit any;
      longint unsigned now;
      longint unsigned earliest;
      longint unsigned comp;
      longint unsigned waited;
      longint unsigned tat;
      longint unsigned wsum;
      longint unsigned tsum;
      job_result_t r;
      if (loaded < JOB_SLOTS) begin
        arr_q[loaded] = arr;
        burst_q[loaded] = burst;
        prio_q[loaded] = prio;
        done_q[loaded] = 1'b0;
        loaded++;
      end
      if (!last) return;
      now = 0;
      finished = 0;
      wsum = 0;
      tsum = 0;
      while (finished < loaded) begin
        found = 1'b0;
        pick = 0;
        best = '0;
        for (int i = 0; i < loaded; i++) begin
          if (!done_q[i] && arr_q[i] <= now && (!found || prio_q[i] < best)) begin
            found = 1'b1;
            best = prio_q[i];
            pick = i;
          end
        end
        if (!found) begin
          any = 1'b0;
          earliest = 0;
          for (int i = 0; i < loaded; i++) begin
            if (!done_q[i] && (!any || arr_q[i] < earliest)) begin
              any = 1'b1;
              earliest = arr_q[i];
            end
          end
          now = earliest;
          continue;
        end
        waited = now - arr_q[pick];
        comp = sat(now + burst_q[pick], TIME_MAX);
        tat = sat(waited + burst_q[pick], TIME_MAX);
        wsum = sat(wsum + waited, SUM_MAX);
        tsum = sat(tsum + tat, SUM_MAX);
        done_q[pick] = 1'b1;
        finished++;
        r.idx = pick[INDEX_W-1:0];
        r.start = now[TIME_W-1:0];
        r.finish = comp[TIME_W-1:0];
        r.waited = waited[TIME_W-1:0];
        r.turnaround = tat[TIME_W-1:0];
        r.wait_total = wsum[SUM_W-1:0];
        r.tat_total = tsum[SUM_W-1:0];
        r.final_job = (finished == loaded);
        expected_results.push_back(r);
        now = comp;
      end
      loaded = 0;
      foreach (done_q[i]) done_q[i] = 1'b0;
    endfunction

    function void compare_field(string name, longint unsigned exp_v,
                                longint unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(job_result_t act);
      job_result_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual index %0d", $time, act.idx);
        return;
      end
      e = expected_results.pop_front();
      compare_field("proc_index", e.idx, act.idx);
      compare_field("start_time", e.start, act.start);
      compare_field("completion_time", e.finish, act.finish);
      compare_field("wait_time", e.waited, act.waited);
      compare_field("turnaround_time", e.turnaround, act.turnaround);
      compare_field("total_wait", e.wait_total, act.wait_total);
      compare_field("total_turnaround", e.tat_total, act.tat_total);
      compare_field("last_result", e.final_job, act.final_job);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               job_valid = 1'b0;
  logic               job_stall;
  logic [ARR_W-1:0]   arrival_time = '0;
  logic [BURST_W-1:0] burst_time = '0;
  logic [PRIO_W-1:0]  priority_level = '0;
  logic               last_process = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [INDEX_W-1:0] proc_index;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W-1:0]  completion_time;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic [SUM_W-1:0]   total_wait;
  logic [SUM_W-1:0]   total_turnaround;
  logic               last_result;

  sched_scoreboard sb = new();
  int items_sent = 0;
  bit quiet = 1'b0;

  nonpreemptive_priority_scheduler i_dut (
    .clk              (clk),
    .rst              (rst),
    .job_valid        (job_valid),
    .job_stall        (job_stall),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_level   (priority_level),
    .last_process     (last_process),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .proc_index       (proc_index),
    .start_time       (start_time),
    .completion_time  (completion_time),
    .wait_time        (wait_time),
    .turnaround_time  (turnaround_time),
    .total_wait       (total_wait),
    .total_turnaround (total_turnaround),
    .last_result      (last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    job_result_t r;
    if (!rst) begin
      if (job_valid && !job_stall) begin
        sb.note_job(arrival_time, burst_time, priority_level, last_process);
      end
      if (result_valid && !result_stall) begin
        r.idx = proc_index;
        r.start = start_time;
        r.finish = completion_time;
        r.waited = wait_time;
        r.turnaround = turnaround_time;
        r.wait_total = total_wait;
        r.tat_total = total_turnaround;
        r.final_job = last_result;
        sb.check_result(r);
      end
    end
  end

  function automatic logic [ARR_W-1:0] rand_arrival();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ARR_W'($urandom_range(0, 40));
      2: return ARR_W'($urandom);
      default: return ARR_W'(65535 - $urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [BURST_W-1:0] rand_burst();
    case ($urandom_range(0, 3))
      0: return BURST_W'(1);
      1: return BURST_W'($urandom_range(1, 30));
      2: return BURST_W'($urandom_range(1, 65535));
      default: return BURST_W'(65535);
    endcase
  endfunction

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return PRIO_W'($urandom_range(0, 3));
      1: return PRIO_W'($urandom);
      2: return '0;
      default: return PRIO_W'(255);
    endcase
  endfunction

  task automatic send_job(input logic [ARR_W-1:0] a, input logic [BURST_W-1:0] b,
                          input logic [PRIO_W-1:0] p, input logic l);
    job_valid <= 1'b1;
    arrival_time <= a;
    burst_time <= b;
    priority_level <= p;
    last_process <= l;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_gap(input int n);
    job_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int len;
    bit calm;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_job(16'd0, 16'd1, 8'd0, 1'b1);
    send_job(16'd65535, 16'd65535, 8'd255, 1'b1);
    send_job(16'd10, 16'd5, 8'd3, 1'b0);
    send_job(16'd0, 16'd2, 8'd3, 1'b0);
    send_job(16'd0, 16'd4, 8'd3, 1'b1);
    // A batch larger than the job store; the extra jobs must be dropped.
    for (int i = 0; i < JOB_SLOTS + 2; i++) begin
      send_job(ARR_W'((17 - i) * 1000), BURST_W'(100 + i * 7), PRIO_W'((i * 37) % 256),
               i == JOB_SLOTS + 1);
    end

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 5);
        7, 8: len = $urandom_range(6, 12);
        default: len = $urandom_range(13, JOB_SLOTS + 3);
      endcase
      calm = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < len; k++) begin
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && !calm && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 19));
        send_job(rand_arrival(), rand_burst(), rand_prio(), k == len - 1);
      end
    end
    quiet = 1'b1;
    job_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.results_seen >= 40) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
